[design/sobm_pkg.sv]
// Shared constants, state encoding and controller/datapath interface types
// for the Sobel edge magnitude block. No dependencies.
package sobm_pkg;

  // Frame limits
  localparam int MAX_WIDTH    = 4096;
  localparam int HEIGHT_LIMIT = 4096;

  // Field and internal widths
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 13;
  localparam int POS_W     = 12;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(HEIGHT_LIMIT);
  localparam int WID_W     = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W     = $clog2(HEIGHT_LIMIT + 1);
  localparam int GRAD_W    = 11;
  localparam int SUMSQ_W   = 21;
  localparam int ROOT_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [ROOT_W-1:0] MAG_CLIP = 8'd255;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GRAD,
    S_SQUARE,
    S_START,
    S_ROOT,
    S_OUT
  } sobm_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // latch pixel, line store read issued
    logic advance;     // window shift, line store write, gradients, counters
    logic square;      // register gx^2 + gy^2
    logic root_start;  // launch square root unit
    logic out_load;    // move result into output register
  } sobm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic interior;    // current pixel completes an interior window
    logic root_done;   // square root result ready
    logic out_free;    // output register can take a result this cycle
  } sobm_status_t;

endpackage

[design/sobel_edge_magnitude.sv]
// Channel  Handshake               Payload
// in       in_valid / in_ready     pixel[7:0]
// out      out_valid / out_ready   magnitude[7:0], out_row[11:0], out_col[11:0], frame_last
// cfg      cfg_valid / cfg_ready   cfg_index[1:0] (0 width, 1 height), cfg_data[12:0]
//
// One pixel at a time: a border pixel takes load and gradients only; an interior
// pixel goes through load, gradients, squares, root start, 8-step bit-serial square
// root and its done flag, output load; a root that clips at 255 skips the steps.
// The serial square root takes most of an interior pixel's time.
// A waiting result sits in the output register; the next pixel is taken
// meanwhile and only its own output load waits for out_ready.
// Reset is synchronous; line stores are not cleared (no result reads them
// before they are written). cfg_ready is always high; a width or height write restarts the frame.
// Top level of the Sobel edge magnitude block. Depends on sobm_pkg,
// sobm_ctrl, sobm_dp.
module sobel_edge_magnitude
  import sobm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     pixel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ROOT_W-1:0]    magnitude,
  output logic [POS_W-1:0]     out_row,
  output logic [POS_W-1:0]     out_col,
  output logic                 frame_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  sobm_cmd_t    cmd;
  sobm_status_t status;

  assign cfg_ready = 1'b1;

  sobm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sobm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel      (pixel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .magnitude  (magnitude),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_last (frame_last)
  );

endmodule

[design/sobm_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/sobm_isqrt.sv]
// Bit-serial floor square root, one result bit per cycle, clipped to 255.
// Depends on sobm_pkg.
module sobm_isqrt
  import sobm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SUMSQ_W-1:0] radicand,
  output logic [ROOT_W-1:0]  root,
  output logic               done
);

  logic [2*ROOT_W-1:0] rad;
  logic [ROOT_W-1:0]   mask;
  logic [ROOT_W-1:0]   cand;
  logic [2*ROOT_W-1:0] cand_sq;
  logic                take;

  // Trial bit: keep it if the candidate squared still fits
  always_comb begin
    cand    = root | mask;
    cand_sq = cand * cand;
    take    = (cand_sq <= rad);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad <= radicand[2*ROOT_W-1:0];
        if (radicand[SUMSQ_W-1:2*ROOT_W] != '0) begin
          // root would exceed the clip level
          root <= MAG_CLIP;
          mask <= '0;
          done <= 1'b1;
        end else begin
          root <= '0;
          mask <= {1'b1, {(ROOT_W-1){1'b0}}};
        end
      end else if (mask != '0) begin
        if (take) begin
          root <= cand;
        end
        mask <= mask >> 1;
        if (mask[0]) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[design/sobm_ctrl.sv]
// Controller FSM: sequences load, gradient, square, root and output steps.
// Depends on sobm_pkg.
module sobm_ctrl
  import sobm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  sobm_status_t status,
  output sobm_cmd_t    cmd
);

  sobm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_GRAD;
        end
      end
      S_GRAD: begin
        cmd.advance = 1'b1;
        state_next  = status.interior ? S_SQUARE : S_IDLE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_START;
      end
      S_START: begin
        cmd.root_start = 1'b1;
        state_next     = S_ROOT;
      end
      S_ROOT: begin
        if (status.root_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[design/sobm_dp.sv]
// Datapath: config registers, position counters, line stores, 3x3 window,
// gradients, sum of squares, square root unit and output register.
// Depends on sobm_pkg, sobm_ram, sobm_isqrt.
module sobm_dp
  import sobm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  sobm_cmd_t            cmd,
  output sobm_status_t         status,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [PIX_W-1:0]     pixel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ROOT_W-1:0]    magnitude,
  output logic [POS_W-1:0]     out_row,
  output logic [POS_W-1:0]     out_col,
  output logic                 frame_last
);

  function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
    logic [WID_W-1:0] r;
    if (v < CFG_W'(3)) r = WID_W'(3);
    else if (32'(v) > MAX_WIDTH) r = WID_W'(MAX_WIDTH);
    else r = WID_W'(v);
    return r;
  endfunction

  function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
    logic [HGT_W-1:0] r;
    if (v < CFG_W'(3)) r = HGT_W'(3);
    else if (32'(v) > HEIGHT_LIMIT) r = HGT_W'(HEIGHT_LIMIT);
    else r = HGT_W'(v);
    return r;
  endfunction

  function automatic logic signed [GRAD_W-1:0] ext(input logic [PIX_W-1:0] p);
    return signed'({{(GRAD_W-PIX_W){1'b0}}, p});
  endfunction

  logic [WID_W-1:0]          width_r;
  logic [HGT_W-1:0]          height_r;
  logic [ROW_W-1:0]          row;
  logic [COL_W-1:0]          col;
  logic [PIX_W-1:0]          bot;
  logic [PIX_W-1:0]          win [6];
  logic [PIX_W-1:0]          top;
  logic [PIX_W-1:0]          mid;
  logic signed [GRAD_W-1:0]  gx, gy, gx_next, gy_next;
  logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
  logic [SUMSQ_W-1:0]        sumsq;
  logic [POS_W-1:0]          res_row, res_col;
  logic                      res_last;
  logic                      col_wrap, row_wrap, interior;
  logic [ROW_W-1:0]          row_m1;
  logic [COL_W-1:0]          col_m1;
  logic [ROOT_W-1:0]         root;
  logic                      root_done;
  logic                      out_free;

  // Line stores: a holds row r-1, b holds row r-2; read at col on load
  sobm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (cmd.advance),
    .waddr (col),
    .wdata (bot),
    .raddr (col),
    .rdata (mid)
  );

  sobm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (cmd.advance),
    .waddr (col),
    .wdata (mid),
    .raddr (col),
    .rdata (top)
  );

  // Position decode
  always_comb begin
    col_wrap = (WID_W'(col) == width_r - WID_W'(1));
    row_wrap = (HGT_W'(row) == height_r - HGT_W'(1));
    interior = (row >= ROW_W'(2)) && (col >= COL_W'(2));
    row_m1   = row - ROW_W'(1);
    col_m1   = col - COL_W'(1);
  end

  // Sobel gradients over window columns c-2, c-1 and incoming column c
  always_comb begin
    gx_next = (ext(top) - ext(win[0])) + ((ext(mid) - ext(win[1])) <<< 1)
            + (ext(bot) - ext(win[2]));
    gy_next = (ext(win[0]) + (ext(win[3]) <<< 1) + ext(top))
            - (ext(win[2]) + (ext(win[5]) <<< 1) + ext(bot));
    gx_sq   = gx * gx;
    gy_sq   = gy * gy;
  end

  // Config registers and position counters; a width or height write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      width_r  <= WID_W'(MAX_WIDTH);
      height_r <= HGT_W'(HEIGHT_LIMIT);
      row      <= '0;
      col      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          width_r <= clamp_width(cfg_data);
          row     <= '0;
          col     <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          height_r <= clamp_height(cfg_data);
          row      <= '0;
          col      <= '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.advance) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // Window
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (cmd.advance) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= bot;
    end
  end

  // Pixel, gradient, position and sum-of-squares registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bot <= pixel;
    end
    if (cmd.advance) begin
      gx       <= gx_next;
      gy       <= gy_next;
      res_row  <= POS_W'(row_m1);
      res_col  <= POS_W'(col_m1);
      res_last <= row_wrap && col_wrap;
    end
    if (cmd.square) begin
      sumsq <= $unsigned(SUMSQ_W'(gx_sq)) + $unsigned(SUMSQ_W'(gy_sq));
    end
  end

  sobm_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_start),
    .radicand (sumsq),
    .root     (root),
    .done     (root_done)
  );

  // Output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      magnitude  <= root;
      out_row    <= res_row;
      out_col    <= res_col;
      frame_last <= res_last;
    end
  end

  always_comb begin
    status.interior  = interior;
    status.root_done = root_done;
    status.out_free  = out_free;
  end

endmodule

[design/sobm_chk.sv]
// Port-level checker for the Sobel edge magnitude block, bound to the top.
// Depends on sobm_pkg and sobel_edge_magnitude.
module sobm_chk
  import sobm_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [ROOT_W-1:0]    magnitude,
  input logic [POS_W-1:0]     out_row,
  input logic [POS_W-1:0]     out_col,
  input logic                 frame_last
);

  // A stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(magnitude) && $stable(out_row)
      && $stable(out_col) && $stable(frame_last))
    else $error("result changed while stalled");

  // Reset empties the output register
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Results only for interior pixels
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_row != '0 && out_col != '0)
    else $error("result on border position");

  // Input is not ready in the cycle after a pixel transfer
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel accepted on consecutive cycles");

endmodule

bind sobel_edge_magnitude sobm_chk u_sobm_chk (.*);

[tb/sobel_edge_magnitude_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sobel_edge_magnitude: streams raster frames of many sizes,
// predicts every edge magnitude and checks each output transfer in order.
// Depends on sobm_pkg and the sobel_edge_magnitude RTL.
module sobel_edge_magnitude_test;
  import sobm_pkg::*;

  localparam int SETTLE_CYCLES = 32;    // interior pixel plus output load, with margin
  localparam int HOLD_AFTER    = 40;    // results before the long receiver stall
  localparam int HOLD_CYCLES   = 500;
  localparam int WIDE_PIXELS   = 40;    // partial first row at the reset width
  localparam int TALL_ROWS     = 100;   // rows sent of the saturated-height frame
  localparam int RANDOM_PIXELS = 680;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum int {
    PAT_FLAT, PAT_COL_LEFT, PAT_COL_RIGHT, PAT_ROW_TOP, PAT_ROW_BOTTOM,
    PAT_RAMP, PAT_BINARY, PAT_NOISE
  } pattern_t;

  typedef struct packed {
    logic [ROOT_W-1:0] magnitude;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              last;
  } edge_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     pixel = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ROOT_W-1:0]    magnitude;
  logic [POS_W-1:0]     out_row;
  logic [POS_W-1:0]     out_col;
  logic                 frame_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Predictor state: registers, two line stores, 3x2 tap window, raster position
  logic [CFG_W-1:0] width_reg  = CFG_W'(MAX_WIDTH);
  logic [CFG_W-1:0] height_reg = CFG_W'(HEIGHT_LIMIT);
  bit [PIX_W-1:0]   line_up1 [MAX_WIDTH];
  bit [PIX_W-1:0]   line_up2 [MAX_WIDTH];
  bit [PIX_W-1:0]   win_taps [6];   // 0..2 column c-2, 3..5 column c-1 (top, mid, bottom)
  int               next_row = 0;
  int               next_col = 0;

  logic [PIX_W-1:0] pixel_backlog [$];
  edge_result_t     mag_expected [$];
  int               mismatches = 0;
  int               results_seen = 0;
  bit               steady = 1'b0;   // no idling on either side while set

  sobel_edge_magnitude uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel(pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .magnitude(magnitude),
    .out_row(out_row),
    .out_col(out_col),
    .frame_last(frame_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_span();
    int pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Out-of-range sizes act as the nearest legal one
  function automatic int frame_dim(input logic [CFG_W-1:0] v, input int top);
    if (v < 3) return 3;
    if (v > top) return top;
    return int'(v);
  endfunction

  // Floor square root, saturated at the clip level
  function automatic logic [ROOT_W-1:0] root_clip(input int unsigned s);
    int unsigned lo, hi, mid;
    if (s >= (int'(MAG_CLIP) + 1) * (int'(MAG_CLIP) + 1)) return MAG_CLIP;
    lo = 0;
    hi = 32'(MAG_CLIP);
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= s) lo = mid;
      else hi = mid - 1;
    end
    return ROOT_W'(lo);
  endfunction

  function automatic void log_error(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("ERROR: %s", msg);
  endfunction

  // One accepted pixel: update window and line stores, queue a magnitude if interior
  task automatic predict_edge(input logic [PIX_W-1:0] p);
    int w, h, r, c, gx, gy;
    int t0, m0, b0, t1, b1, t2, m2, b2;
    edge_result_t res;
    w = frame_dim(width_reg, MAX_WIDTH);
    h = frame_dim(height_reg, HEIGHT_LIMIT);
    r = next_row;
    c = next_col;
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    t2 = int'(line_up2[c]);
    m2 = int'(line_up1[c]);
    b2 = int'(p);
    if (r >= 2 && c >= 2) begin
      t0 = int'(win_taps[0]);
      m0 = int'(win_taps[1]);
      b0 = int'(win_taps[2]);
      t1 = int'(win_taps[3]);
      b1 = int'(win_taps[5]);
      gx = (t2 - t0) + 2 * (m2 - m0) + (b2 - b0);
      gy = (t0 + 2 * t1 + t2) - (b0 + 2 * b1 + b2);
      res.magnitude = root_clip(gx * gx + gy * gy);
      res.row = POS_W'(r - 1);
      res.col = POS_W'(c - 1);
      res.last = (r == h - 1 && c == w - 1);
      mag_expected.push_back(res);
    end
    win_taps[0] = win_taps[3];
    win_taps[1] = win_taps[4];
    win_taps[2] = win_taps[5];
    win_taps[3] = PIX_W'(t2);
    win_taps[4] = PIX_W'(m2);
    win_taps[5] = p;
    line_up2[c] = PIX_W'(m2);
    line_up1[c] = p;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_row = r;
    next_col = c;
  endtask

  // Register write as seen by the predictor; only the two size registers restart the frame
  task automatic load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = data;
        next_row = 0;
        next_col = 0;
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = data;
        next_row = 0;
        next_col = 0;
      end
      default: ;
    endcase
  endtask

  // Config transfer; 'more' keeps valid up for a following write
  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                             input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    load_reg(idx, data);
    if (!more) cfg_valid <= 1'b0;
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    program_reg(REG_IMAGE_WIDTH, w, 1'b1);
    program_reg(REG_IMAGE_HEIGHT, h, 1'b0);
  endtask

  // Queue raster positions first .. first+count-1 of a frame 'w' pixels wide
  task automatic queue_pixels(input int w, input int first, input int count,
                              input pattern_t kind, input int amp);
    int r, c;
    logic [PIX_W-1:0] v;
    for (int i = first; i < first + count; i++) begin
      r = i / w;
      c = i % w;
      case (kind)
        PAT_FLAT:       v = PIX_W'(amp);
        PAT_COL_LEFT:   v = (c % 3 == 0) ? PIX_W'(amp) : '0;
        PAT_COL_RIGHT:  v = (c % 3 == 2) ? PIX_W'(amp) : '0;
        PAT_ROW_TOP:    v = (r % 3 == 0) ? PIX_W'(amp) : '0;
        PAT_ROW_BOTTOM: v = (r % 3 == 2) ? PIX_W'(amp) : '0;
        PAT_RAMP:       v = PIX_W'((c * 9 + r * 5) % (amp + 1));
        PAT_BINARY:     v = $urandom_range(0, 1) ? PIX_W'(amp) : '0;
        default:        v = PIX_W'($urandom_range(0, amp));
      endcase
      pixel_backlog.push_back(v);
    end
  endtask

  // Block is idle: nothing queued or offered, every result back, pipeline settled
  task automatic drain();
    while (pixel_backlog.size() > 0 || in_valid || mag_expected.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pixel driver: predicts on each input transfer, then idles or offers the next pixel
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_edge(pixel);
        send_gap = idle_span();
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (pixel_backlog.size() > 0) begin
          in_valid <= 1'b1;
          pixel <= pixel_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver pacing, including one long stall
  int ready_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  edge_result_t got, want;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {magnitude, out_row, out_col, frame_last};
        results_seen++;
        if (mag_expected.size() == 0) begin
          log_error($sformatf("result %0d unexpected: mag %0d row %0d col %0d last %0b",
                              results_seen, got.magnitude, got.row, got.col, got.last));
        end else begin
          want = mag_expected.pop_front();
          if (got.magnitude !== want.magnitude || got.row !== want.row ||
              got.col !== want.col || got.last !== want.last)
            log_error($sformatf(
              "result %0d: got mag/row/col/last %0d/%0d/%0d/%0b, want %0d/%0d/%0d/%0b",
              results_seen, got.magnitude, got.row, got.col, got.last,
              want.magnitude, want.row, want.col, want.last));
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (ready_gap > 0) begin
        out_ready <= 1'b0;
        ready_gap--;
      end else begin
        out_ready <= 1'b1;
        ready_gap = idle_span();
      end
    end
  end

  // Stimulus sequence
  initial begin
    int w_raw, h_raw, w, h, frames, cut, amp, sent;
    pattern_t kind;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset width with height 2 acting as 3: a partial first row gives no results
    steady = 1'b1;
    program_reg(REG_IMAGE_HEIGHT, 13'd2, 1'b0);
    queue_pixels(MAX_WIDTH, 0, WIDE_PIXELS, PAT_NOISE, 63);
    drain();

    // Tall frame: width 1 acts as 3, oversize height saturates; the long
    // receiver stall falls here while the sender keeps offering pixels
    set_size(13'd1, 13'h1FFF);
    queue_pixels(3, 0, 3 * TALL_ROWS, PAT_NOISE, 63);
    drain();
    steady = 1'b0;

    // Smallest frames with full-scale edges; back-to-back frames exercise the wrap
    set_size('0, '0);
    queue_pixels(3, 0, 9, PAT_COL_RIGHT, 255);
    queue_pixels(3, 0, 9, PAT_ROW_BOTTOM, 255);
    queue_pixels(3, 0, 9, PAT_FLAT, 255);
    drain();

    // Spare register indexes must leave a frame in progress alone
    set_size(13'd6, 13'd5);
    queue_pixels(6, 0, 15, PAT_NOISE, 255);
    drain();
    program_reg(REG_SPARE_2, 13'h1FFF, 1'b1);
    program_reg(REG_SPARE_3, 13'h0AAA, 1'b0);
    queue_pixels(6, 15, 15, PAT_RAMP, 255);
    // Start of the next frame, then a single height write restarts it
    queue_pixels(6, 0, 8, PAT_NOISE, 255);
    drain();
    program_reg(REG_IMAGE_HEIGHT, 13'd4, 1'b0);
    queue_pixels(6, 0, 24, PAT_BINARY, 255);
    drain();

    // Random small frames, mostly complete, some cut short by the next write
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      w_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      h_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      w = frame_dim(CFG_W'(w_raw), MAX_WIDTH);
      h = frame_dim(CFG_W'(h_raw), HEIGHT_LIMIT);
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0)
        program_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CFG_W'($urandom), 1'b1);
      set_size(CFG_W'(w_raw), CFG_W'(h_raw));
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        kind = ($urandom_range(0, 9) < 5) ? PAT_NOISE : pattern_t'($urandom_range(0, 7));
        case ($urandom_range(0, 2))
          0:       amp = 15;
          1:       amp = 63;
          default: amp = 255;
        endcase
        cut = (f == frames - 1 && $urandom_range(0, 4) == 0) ?
              $urandom_range(1, w * h - 1) : w * h;
        queue_pixels(w, 0, cut, kind, amp);
        sent += cut;
      end
      drain();
    end

    if (mismatches == 0 && mag_expected.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
design/sobm_pkg.sv
design/sobm_ram.sv
design/sobm_isqrt.sv
design/sobm_ctrl.sv
design/sobm_dp.sv
design/sobel_edge_magnitude.sv
design/sobm_chk.sv
tb/sobel_edge_magnitude_test.sv
